/* design/sfr_pkg.sv */
package sfr_pkg;

    localparam int unsigned ByteW = 8;

    // result kinds carried on m_tuser
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_GOOD   = 2'd1,
        KIND_BADSUM = 2'd2,
        KIND_BADLEN = 2'd3
    } kind_t;

    // one result item
    typedef struct packed {
        logic [ByteW-1:0] frame_length;
        logic [ByteW-1:0] data;
        kind_t            kind;
    } result_t;

    // handshake between input register and frame core
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] rx_byte;
    } in_item_t;

endpackage

/* design/serial_frame_receiver_dual_sum_top.sv */
// Channel   Dir  Signals                        Contents (low bit first)
// s_        in   s_tvalid s_tready s_tdata      tdata[7:0] rx_byte
// m_        out  m_tvalid m_tready m_tdata      tdata[7:0] data, [15:8] frame_length
//                m_tuser                        tuser[1:0] kind
// cfg_      in   cfg_valid cfg_ready cfg_data   cfg_data[7:0] start_byte
//
// One request per cycle sustained while m_ is not stalled. An accepted byte
// sits in the input register; its result (if any) then passes through the
// frame core into the output register. The rate is set by the single pass
// through the frame core between those two registers.
// rst_n (async, active low) clears phase, sums, counters, start_byte and
// both valid flags. A stalled m_ side holds its result; s_tready stays high
// while the input register is empty, so one more byte is taken during a stall.
// cfg_ready is always high; start_byte changes take effect at the next hunt.
module serial_frame_receiver_dual_sum_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] rx_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,   // [7:0] data, [15:8] frame_length
    output logic [1:0]                m_tuser,   // [1:0] kind
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [sfr_pkg::ByteW-1:0] cfg_data   // [7:0] start_byte
);
    import sfr_pkg::*;

    in_item_t item;
    logic     take;
    result_t  res;

    // input register: decouples s_ from the output stall
    sfr_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .item     (item)
    );

    // frame state machine, dual checksum and result register
    sfr_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .item      (item),
        .take      (take),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.frame_length, res.data};
    assign m_tuser = res.kind;

endmodule

/* design/sfr_in_stage.sv */
module sfr_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [sfr_pkg::ByteW-1:0] s_tdata,
    input  logic                    take,
    output sfr_pkg::in_item_t       item
);
    import sfr_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    logic [ByteW-1:0] byte_reg;

    // empty slot, or the held byte leaves this cycle
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

    assign item.valid   = valid_reg;
    assign item.rx_byte = byte_reg;

endmodule

/* design/sfr_frame_core.sv */
module sfr_frame_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [sfr_pkg::ByteW-1:0] cfg_data,
    input  sfr_pkg::in_item_t         item,
    output logic                      take,
    output logic                      res_valid,
    input  logic                      res_ready,
    output sfr_pkg::result_t          res
);
    import sfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CK1  = 3'd3,
        PH_CK2  = 3'd4
    } phase_t;

    phase_t           phase_reg,    phase_next;
    logic [ByteW-1:0] start_reg;
    logic [ByteW-1:0] exp_len_reg,  exp_len_next;
    logic [ByteW-1:0] seen_reg,     seen_next;
    logic [ByteW-1:0] sum1_reg,     sum1_next;
    logic [ByteW-1:0] sum2_reg,     sum2_next;
    logic             ck1_ok_reg,   ck1_ok_next;
    logic             out_vld_reg,  out_vld_next;
    result_t          out_reg;

    logic             emit;
    result_t          emit_res;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] sum1_add;
    logic [ByteW-1:0] seen_inc;
    logic [ByteW:0]   seen_end;

    assign cfg_ready = 1'b1;
    assign b         = item.rx_byte;
    assign take      = item.valid && (!out_vld_reg || res_ready);

    assign sum1_add = sum1_reg + b;
    assign seen_inc = seen_reg + 8'd1;
    assign seen_end = {1'b0, seen_inc} + 9'd2;

    always_comb
    begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        sum1_next    = sum1_reg;
        sum2_next    = sum2_reg;
        ck1_ok_next  = ck1_ok_reg;
        emit                  = 1'b0;
        emit_res.kind         = KIND_DATA;
        emit_res.data         = '0;
        emit_res.frame_length = exp_len_reg;
        unique case (phase_reg)
            PH_LEN:
            begin
                exp_len_next          = b;
                seen_next             = 8'd2;
                emit_res.frame_length = b;
                if (b < 8'd4)
                begin
                    phase_next    = PH_HUNT;
                    emit          = 1'b1;
                    emit_res.kind = KIND_BADLEN;
                end
                else
                begin
                    sum1_next  = sum1_add;
                    sum2_next  = sum2_reg + sum1_add;
                    phase_next = (b == 8'd4) ? PH_CK1 : PH_DATA;
                end
            end
            PH_DATA:
            begin
                sum1_next = sum1_add;
                sum2_next = sum2_reg + sum1_add;
                seen_next = seen_inc;
                if (seen_end >= {1'b0, exp_len_reg})
                begin
                    phase_next = PH_CK1;
                end
                emit          = 1'b1;
                emit_res.kind = KIND_DATA;
                emit_res.data = b;
            end
            PH_CK1:
            begin
                ck1_ok_next = (b == sum1_reg);
                seen_next   = seen_inc;
                phase_next  = PH_CK2;
            end
            PH_CK2:
            begin
                seen_next     = seen_inc;
                phase_next    = PH_HUNT;
                emit          = 1'b1;
                emit_res.kind = (ck1_ok_reg && b == sum2_reg) ? KIND_GOOD : KIND_BADSUM;
            end
            default:
            begin
                // hunt; stray encodings fall back here
                phase_next = PH_HUNT;
                if (b == start_reg)
                begin
                    phase_next  = PH_LEN;
                    seen_next   = 8'd1;
                    sum1_next   = '0;
                    sum2_next   = '0;
                    ck1_ok_next = 1'b0;
                end
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (take)
        begin
            out_vld_next = emit;
        end
        else if (res_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            start_reg   <= '0;
            exp_len_reg <= '0;
            seen_reg    <= '0;
            sum1_reg    <= '0;
            sum2_reg    <= '0;
            ck1_ok_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                start_reg <= cfg_data;
            end
            if (take)
            begin
                phase_reg   <= phase_next;
                exp_len_reg <= exp_len_next;
                seen_reg    <= seen_next;
                sum1_reg    <= sum1_next;
                sum2_reg    <= sum2_next;
                ck1_ok_reg  <= ck1_ok_next;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg <= emit_res;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

endmodule

/* design/sfr_checker.sv */
module sfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import sfr_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only payload results carry data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_DATA |-> m_tdata[7:0] == 8'd0)
        else $error("nonzero data on verdict");

    // bad length verdict only for lengths below four
    a_badlen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_BADLEN |-> m_tdata[15:8] < 8'd4)
        else $error("bad length verdict on legal length");

    // payload only exists in frames of five bytes or more
    a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_DATA |-> m_tdata[15:8] >= 8'd5)
        else $error("payload in frame without payload");

endmodule

bind serial_frame_receiver_dual_sum_top sfr_checker u_sfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* test/tb_serial_frame_receiver_dual_sum_top.sv */
module tb_serial_frame_receiver_dual_sum_top;

    import sfr_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 12;
    localparam int FLUSH_CYCLES  = 8;   // drain margin after the last due result
    localparam int RANDOM_ITEMS  = 1500;

    // receiver-side frame tracking, mirrors the block's own phases
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK1,
        PH_CHECK2
    } rx_phase_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;    // [7:0] data, [15:8] frame_length
    logic [1:0]           m_tuser;    // [1:0] kind
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ByteW-1:0]     cfg_data;   // [7:0] start_byte

    // frame tracker state and configuration copy
    rx_phase_t            trk_phase;
    logic [7:0]           trk_start_byte;
    logic [7:0]           trk_length;
    logic [7:0]           trk_bytes_seen;
    logic [7:0]           trk_sum_a;
    logic [7:0]           trk_sum_b;
    logic                 trk_check1_ok;

    result_t              frame_results_due[$];
    int                   error_count;
    int                   bytes_sent;
    int                   tx_idle_pct;
    int                   rx_hold_left;

    serial_frame_receiver_dual_sum_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * 1_000_000);
        $display("tb_serial_frame_receiver_dual_sum_top: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // frame tracker: expected results for one accepted byte
    // ---------------------------------------------------------------
    task automatic push_result(input kind_t kind, input logic [7:0] data);
        result_t r;
        r.kind         = kind;
        r.data         = data;
        r.frame_length = trk_length;
        frame_results_due.push_back(r);
    endtask

    task automatic track_byte(input logic [7:0] b);
        case (trk_phase)
            PH_LENGTH:
            begin
                trk_length     = b;
                trk_bytes_seen = 8'd2;
                if (b < 8'd4)
                begin
                    trk_phase = PH_HUNT;
                    push_result(KIND_BADLEN, 8'd0);
                end
                else
                begin
                    trk_sum_a = trk_sum_a + b;
                    trk_sum_b = trk_sum_b + trk_sum_a;
                    trk_phase = (b == 8'd4) ? PH_CHECK1 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                trk_sum_a      = trk_sum_a + b;
                trk_sum_b      = trk_sum_b + trk_sum_a;
                trk_bytes_seen = trk_bytes_seen + 8'd1;
                if (int'(trk_bytes_seen) + 2 >= int'(trk_length))
                    trk_phase = PH_CHECK1;
                push_result(KIND_DATA, b);
            end
            PH_CHECK1:
            begin
                trk_check1_ok  = (b == trk_sum_a);
                trk_bytes_seen = trk_bytes_seen + 8'd1;
                trk_phase      = PH_CHECK2;
            end
            PH_CHECK2:
            begin
                trk_bytes_seen = trk_bytes_seen + 8'd1;
                trk_phase      = PH_HUNT;
                if (trk_check1_ok && b == trk_sum_b)
                    push_result(KIND_GOOD, 8'd0);
                else
                    push_result(KIND_BADSUM, 8'd0);
            end
            default:
            begin
                trk_phase = PH_HUNT;
                if (b == trk_start_byte)
                begin
                    trk_phase      = PH_LENGTH;
                    trk_bytes_seen = 8'd1;
                    trk_sum_a      = 8'd0;
                    trk_sum_b      = 8'd0;
                    trk_check1_ok  = 1'b0;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int pick_idle(input int pct);
        if (pct == 0 || $urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int idle;
        idle = pick_idle(tx_idle_pct);
        if (idle > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_byte(b);
        bytes_sent++;
    endtask

    // start byte, length, payload, two checksum bytes; spoil bit 0/1 corrupts
    // the first/second checksum byte
    task automatic send_frame(input logic [7:0] len, input logic [7:0] payload[$],
                              input int spoil);
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        sum_a = len;
        sum_b = len;
        foreach (payload[i])
        begin
            sum_a = sum_a + payload[i];
            sum_b = sum_b + sum_a;
        end
        if (spoil[0])
            sum_a = sum_a ^ 8'($urandom_range(1, 255));
        if (spoil[1])
            sum_b = sum_b ^ 8'($urandom_range(1, 255));
        send_byte(trk_start_byte);
        send_byte(len);
        foreach (payload[i])
            send_byte(payload[i]);
        send_byte(sum_a);
        send_byte(sum_b);
    endtask

    // drop valid, wait for every due result, then let in-flight bytes settle
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        trk_start_byte = value;
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // receiver side: random stalls, stall-free bursts, and long hold-offs
    // ---------------------------------------------------------------
    initial
    begin
        int stall_left;
        int burst_left;
        stall_left = 0;
        burst_left = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 15) == 0)
                    burst_left = $urandom_range(20, 200);
                else
                    stall_left = pick_idle(35);
            end
        end
    end

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_results_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, %s %0d data %0h len %0h",
                         $time, "actual kind", m_tuser, m_tdata[7:0], m_tdata[15:8]);
                error_count++;
            end
            else
            begin
                want = frame_results_due.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", 16'(want.kind), 16'(m_tuser));
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("data", 16'(want.data), 16'(m_tdata[7:0]));
                if (m_tdata[15:8] !== want.frame_length)
                    report_mismatch("frame_length", 16'(want.frame_length),
                                    16'(m_tdata[15:8]));
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    // reset start byte of zero, length of exactly four: no payload
    task automatic test_min_frame();
        logic [7:0] none[$];
        send_frame(8'd4, none, 0);
    endtask

    // lengths below four are rejected right after the length byte
    task automatic test_bad_length();
        wait_until_drained();
        write_start_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(8'd3);
    endtask

    // payload extremes, including the start byte value inside a frame
    task automatic test_payload_extremes();
        logic [7:0] payload[$];
        payload = '{8'hFF, 8'h00, 8'h7F, 8'h80};
        send_frame(8'd8, payload, 0);
    endtask

    // start byte rewritten mid-frame; wrong first checksum byte
    task automatic test_checksum_error_cfg_midframe();
        send_byte(8'hFF);
        send_byte(8'd6);
        send_byte(8'h12);
        send_byte(8'h34);
        wait_until_drained();
        write_start_byte(8'h3C);
        send_byte(8'h4D);   // correct would be 4C
        send_byte(8'h6A);
        send_byte(8'hFF);   // old start byte, ignored while hunting
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_output_backpressure();
        logic [7:0] payload[$];
        wait_until_drained();
        tx_idle_pct  = 0;
        rx_hold_left = 150;
        repeat (3)
        begin
            payload.delete();
            repeat (20)
                payload.push_back(8'($urandom));
            send_frame(8'd24, payload, 0);
        end
        wait_until_drained();
    endtask

    function automatic logic [7:0] pick_frame_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 8'd255;
        if (r < 7)
            return 8'($urandom_range(41, 254));
        if (r < 22)
            return 8'($urandom_range(13, 40));
        return 8'($urandom_range(4, 12));
    endfunction

    // mostly well-formed frames; also bad lengths, line noise, cut-off frames
    task automatic test_random_traffic();
        logic [7:0] start_values[6];
        int         idle_pcts[6];
        logic [7:0] payload[$];
        logic [7:0] len;
        int         pick;
        int         phase_end;
        start_values = '{8'h00, 8'hFF, 8'($urandom), 8'hA5, 8'($urandom), 8'h5A};
        idle_pcts    = '{0, 25, 60, 10, 0, 40};
        foreach (start_values[p])
        begin
            wait_until_drained();
            write_start_byte(start_values[p]);
            tx_idle_pct = idle_pcts[p];
            phase_end   = bytes_sent + RANDOM_ITEMS / 6;
            while (bytes_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    len = pick_frame_length();
                    payload.delete();
                    repeat (int'(len) - 4)
                        payload.push_back(8'($urandom));
                    send_frame(len, payload,
                               ($urandom_range(0, 99) < 15) ? $urandom_range(1, 3) : 0);
                end
                else if (pick < 78)
                begin
                    send_byte(trk_start_byte);
                    send_byte(8'($urandom_range(0, 3)));
                end
                else if (pick < 90)
                begin
                    repeat ($urandom_range(1, 5))
                        send_byte(8'($urandom));
                end
                else
                begin
                    len = 8'($urandom_range(4, 20));
                    send_byte(trk_start_byte);
                    send_byte(len);
                    repeat ($urandom_range(0, int'(len) - 3))
                        send_byte(8'($urandom));
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'd0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        trk_phase      = PH_HUNT;
        trk_start_byte = 8'd0;
        trk_length     = 8'd0;
        trk_bytes_seen = 8'd0;
        trk_sum_a      = 8'd0;
        trk_sum_b      = 8'd0;
        trk_check1_ok  = 1'b0;
        error_count    = 0;
        bytes_sent     = 0;
        tx_idle_pct    = 20;
        rx_hold_left   = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_min_frame();
        test_bad_length();
        test_payload_extremes();
        test_checksum_error_cfg_midframe();
        test_output_backpressure();
        test_random_traffic();

        wait_until_drained();
        if (error_count == 0)
            $display("tb_serial_frame_receiver_dual_sum_top: done, clean");
        else
            $display("tb_serial_frame_receiver_dual_sum_top: done, errors");
        $finish;
    end

endmodule

/* serial_frame_receiver_dual_sum_top.f */
design/sfr_pkg.sv
design/sfr_in_stage.sv
design/sfr_frame_core.sv
design/serial_frame_receiver_dual_sum_top.sv
design/sfr_checker.sv
test/tb_serial_frame_receiver_dual_sum_top.sv
